[hdl/u8u16_pkg.sv]
// ---------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// ---------------------------------------------------------------------------
package u8u16_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [20:0] MIN_CP_2   = 21'h00080;
  localparam logic [20:0] MIN_CP_3   = 21'h00800;
  localparam logic [20:0] MIN_CP_4   = 21'h10000;
  localparam logic [20:0] MAX_CP     = 21'h10FFFF;
  localparam logic [20:0] MAX_BMP    = 21'h00FFFF;
  localparam logic [20:0] SURR_LO    = 21'h0D800;
  localparam logic [20:0] SURR_HI    = 21'h0DFFF;
  localparam logic [5:0]  HI_SURR_PFX = 6'b110110;  // 0xD800 >> 10
  localparam logic [5:0]  LO_SURR_PFX = 6'b110111;  // 0xDC00 >> 10

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_LEAD  = 3'd1,
    ERR_TRUNCATED = 3'd2,
    ERR_BAD_CONT  = 3'd3,
    ERR_INVALID   = 3'd4
  } err_t;

  typedef struct packed {
    logic [15:0] code_unit;
    err_t        error_code;
    logic        last_of_run;
    logic        text_done;
  } result_t;

endpackage

[hdl/u8u16_if.sv]
// ---------------------------------------------------------------------------
// u8u16_in_if / u8u16_out_if
// Valid/ready channels: UTF-8 bytes in, UTF-16 units out.
// ---------------------------------------------------------------------------
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic [2:0]  error_code;
  logic        last_of_run;
  logic        text_done;

  modport source (output valid, output code_unit, output error_code,
                  output last_of_run, output text_done, input ready);
  modport sink   (input valid, input code_unit, input error_code,
                  input last_of_run, input text_done, output ready);
endinterface

[hdl/utf8_to_utf16_decoder.sv]
// ---------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Streaming UTF-8 to UTF-16 transcoder with error reporting.
//
// Takes one UTF-8 byte per cycle while the input side is ready. Each transfer
// is decoded in the cycle it is accepted; its results (none, one unit, a
// surrogate pair or one error) land in a 4-entry result queue and are visible
// in the next cycle. The input side is ready while at least two queue slots
// are free, so with the unit side always ready the text runs at one byte per
// cycle whatever its content: a surrogate pair is two output units, but its
// 4-byte sequence was four input bytes. Back-pressure on the unit side stalls
// the input once three results are waiting. After an error the rest of the
// text is dropped up to and including its last byte.
// ---------------------------------------------------------------------------
module utf8_to_utf16_decoder
  import u8u16_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  u8u16_in_if.sink     byte_ch,
  u8u16_out_if.source  unit_ch
);

  // decoder state
  logic [20:0] partial_point, partial_point_next;
  logic [2:0]  sequence_length, sequence_length_next;
  logic [1:0]  bytes_remaining, bytes_remaining_next;
  logic        bad_continuation_seen, bad_continuation_seen_next;
  logic        discarding, discarding_next;

  // result queue
  result_t     fifo [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  logic        accept, pop;
  logic [1:0]  wr_n;
  result_t     res0, res1;

  logic [7:0]  b;
  logic        eot;
  logic [20:0] cp;
  logic [19:0] v;
  logic        bad_next, overlong;
  err_t        err;

  assign accept = byte_ch.valid && byte_ch.ready;
  assign pop    = unit_ch.valid && unit_ch.ready;
  assign b      = byte_ch.text_byte;
  assign eot    = byte_ch.end_of_text;

  assign cp = {partial_point[14:0], b[5:0]};
  assign v  = 20'(cp - MIN_CP_4);

  always_comb begin
    partial_point_next         = partial_point;
    sequence_length_next       = sequence_length;
    bytes_remaining_next       = bytes_remaining;
    bad_continuation_seen_next = bad_continuation_seen;
    discarding_next            = discarding;
    err      = ERR_NONE;
    wr_n     = 2'd0;
    res0     = '{code_unit: 16'h0, error_code: ERR_NONE, last_of_run: 1'b1,
                 text_done: eot};
    res1     = res0;
    bad_next = bad_continuation_seen || (b[7:6] != 2'b10);
    overlong = 1'b0;

    if (accept) begin
      if (discarding) begin
        // swallow everything up to the end of the text
      end else if (bytes_remaining == 2'd0) begin
        if (!b[7]) begin
          res0.code_unit = {8'h00, b};
          wr_n = 2'd1;
        end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
          if (eot) begin
            err = ERR_TRUNCATED;
          end else begin
            bad_continuation_seen_next = 1'b0;
            if (!b[5]) begin
              partial_point_next   = {16'h0, b[4:0]};
              sequence_length_next = 3'd2;
              bytes_remaining_next = 2'd1;
            end else if (!b[4]) begin
              partial_point_next   = {17'h0, b[3:0]};
              sequence_length_next = 3'd3;
              bytes_remaining_next = 2'd2;
            end else begin
              partial_point_next   = {18'h0, b[2:0]};
              sequence_length_next = 3'd4;
              bytes_remaining_next = 2'd3;
            end
          end
        end else begin
          err = ERR_BAD_LEAD;
        end
      end else if (bytes_remaining == 2'd1) begin
        // sequence completes on this byte
        case (sequence_length)
          3'd2:    overlong = cp < MIN_CP_2;
          3'd3:    overlong = cp < MIN_CP_3;
          3'd4:    overlong = cp < MIN_CP_4;
          default: overlong = 1'b0;
        endcase
        if (bad_next) begin
          err = ERR_BAD_CONT;
        end else if (overlong || cp > MAX_CP || cp inside {[SURR_LO:SURR_HI]}) begin
          err = ERR_INVALID;
        end else if (cp <= MAX_BMP) begin
          res0.code_unit = cp[15:0];
          wr_n = 2'd1;
        end else begin
          res0.code_unit   = {HI_SURR_PFX, v[19:10]};
          res0.last_of_run = 1'b0;
          res1.code_unit   = {LO_SURR_PFX, v[9:0]};
          wr_n = 2'd2;
        end
        partial_point_next         = '0;
        sequence_length_next       = '0;
        bytes_remaining_next       = '0;
        bad_continuation_seen_next = 1'b0;
      end else if (eot) begin
        // bad continuation is hidden by truncation
        err = ERR_TRUNCATED;
      end else begin
        partial_point_next         = cp;
        bytes_remaining_next       = bytes_remaining - 2'd1;
        bad_continuation_seen_next = bad_next;
      end

      if (err != ERR_NONE) begin
        res0.code_unit   = 16'h0;
        res0.error_code  = err;
        res0.last_of_run = 1'b1;
        wr_n = 2'd1;
        partial_point_next         = '0;
        sequence_length_next       = '0;
        bytes_remaining_next       = '0;
        bad_continuation_seen_next = 1'b0;
        discarding_next            = !eot;
      end

      if (eot) begin
        partial_point_next         = '0;
        sequence_length_next       = '0;
        bytes_remaining_next       = '0;
        bad_continuation_seen_next = 1'b0;
        discarding_next            = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_point         <= '0;
      sequence_length       <= '0;
      bytes_remaining       <= '0;
      bad_continuation_seen <= 1'b0;
      discarding            <= 1'b0;
      wr_ptr                <= '0;
      rd_ptr                <= '0;
      count                 <= '0;
    end else begin
      partial_point         <= partial_point_next;
      sequence_length       <= sequence_length_next;
      bytes_remaining       <= bytes_remaining_next;
      bad_continuation_seen <= bad_continuation_seen_next;
      discarding            <= discarding_next;
      wr_ptr <= wr_ptr + PTR_W'(wr_n);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(wr_n) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) begin
      fifo[wr_ptr] <= res0;
    end
    if (wr_n == 2'd2) begin
      fifo[wr_ptr + PTR_W'(1)] <= res1;
    end
  end

  // room for a surrogate pair
  assign byte_ch.ready = count <= CNT_W'(FIFO_DEPTH - 2);

  assign unit_ch.valid       = count != '0;
  assign unit_ch.code_unit   = fifo[rd_ptr].code_unit;
  assign unit_ch.error_code  = fifo[rd_ptr].error_code;
  assign unit_ch.last_of_run = fifo[rd_ptr].last_of_run;
  assign unit_ch.text_done   = fifo[rd_ptr].text_done;

  // queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // high surrogate is always followed by its low half already queued
  a_pair_queued: assert property (@(posedge clk) disable iff (rst)
    unit_ch.valid && !unit_ch.last_of_run |-> count >= CNT_W'(2))
    else $error("surrogate pair split in queue");

  // dropped bytes produce nothing
  a_discard_silent: assert property (@(posedge clk) disable iff (rst)
    accept && discarding |-> wr_n == 2'd0)
    else $error("result while discarding");

  // open sequence bookkeeping is consistent
  a_seq_state: assert property (@(posedge clk) disable iff (rst)
    bytes_remaining != 2'd0 |->
      sequence_length > {1'b0, bytes_remaining} && !discarding)
    else $error("inconsistent sequence state");

endmodule
